// ----- hdl/swfp_pkg.sv -----
// Shared types and constants for the sliding window frame percentile block.
package swfp_pkg;

  localparam int FRAME_W = 24;
  localparam int AVG_W   = 32;
  localparam int ALPHA_W = 16;
  localparam int OCNT_W  = 8;

  localparam logic [FRAME_W-1:0] THRESH_RST = 24'd25000;
  localparam logic [ALPHA_W-1:0] ALPHA_RST  = 16'd5243;

  localparam logic REG_HITCH = 1'b0;
  localparam logic REG_ALPHA = 1'b1;

  typedef struct packed {
    logic [FRAME_W-1:0] sample;
    logic               nonzero;
  } item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] threshold;
    logic [ALPHA_W-1:0] alpha;
  } cfg_t;

endpackage

// ----- hdl/swfp_front.sv -----
// Front end: accept words, saturate and classify them, queue them for the back end.
module swfp_front import swfp_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [FRAME_W-1:0] frame_time_us_i,
  output logic               in_stall_o,
  output logic               item_valid_o,
  output item_t              item_o,
  input  logic               pop_i
);

  localparam logic [FRAME_W-1:0] SAT_MAX = (SAMPLE_WIDTH >= FRAME_W) ? {FRAME_W{1'b1}} :
                                           FRAME_W'((64'd1 << SAMPLE_WIDTH) - 64'd1);

  item_t       slot_q [2];
  logic        wr_ptr_q, wr_ptr_d;
  logic        rd_ptr_q, rd_ptr_d;
  logic [1:0]  cnt_q, cnt_d;
  logic        push;
  item_t       new_item;

  assign in_stall_o   = (cnt_q == 2'd2);
  assign push         = in_valid_i && !in_stall_o;
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];

  always_comb begin
    new_item.sample  = (frame_time_us_i > SAT_MAX) ? SAT_MAX : frame_time_us_i;
    new_item.nonzero = (frame_time_us_i != '0);
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// ----- hdl/swfp_back.sv -----
// Back end: window memory, moving average and radix rank selection of the percentiles.
module swfp_back import swfp_pkg::*; #(
  parameter int WINDOW_DEPTH = 240,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               item_valid_i,
  input  item_t              item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FRAME_W-1:0] current_frame_us_o,
  output logic [AVG_W-1:0]   smoothed_frame_q8_o,
  output logic [FRAME_W-1:0] p95_frame_us_o,
  output logic [FRAME_W-1:0] p99_frame_us_o,
  output logic [FRAME_W-1:0] max_frame_us_o,
  output logic [OCNT_W-1:0]  hitch_total_o,
  output logic [OCNT_W-1:0]  window_fill_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int XW = $clog2(WINDOW_DEPTH * 99 + 100);
  localparam logic [25:0] RECIP = 26'd42949673;  // ceil(2^32 / 100)
  localparam logic [CW-1:0] DEPTH_C = CW'(WINDOW_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(WINDOW_DEPTH - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WRITE = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_ADD   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [SW-1:0] mem [WINDOW_DEPTH];
  logic [SW-1:0] rd_data_q;

  logic [2:0]          state_q, state_d;
  item_t               item_q;
  logic [AW-1:0]       slot_q;
  logic [CW-1:0]       fill_q;
  logic [AVG_W-1:0]    avg_q;
  logic                avg_zero_q;
  logic signed [32:0]  diff_q;
  logic signed [49:0]  prod_q;
  logic [XW-1:0]       x95_q, x99_q;
  logic [CW-1:0]       r95_q, r99_q, cnt95_q, cnt99_q;
  logic [SW-1:0]       pre95_q, pre99_q, mask_q, bit_q, max_q;
  logic [CW-1:0]       hitch_q;
  logic                first_q, iss_q, rd_vld_q, rd_last_q;
  logic [AW-1:0]       rd_addr_q;

  logic [AVG_W-1:0]    target;
  logic signed [33:0]  step;
  logic                m95, m99, mem_we, mem_re;
  logic [CW-1:0]       c95_n, c99_n;
  logic [XW+25:0]      q95_p, q99_p;

  logic                out_load;
  logic                out_vld_q;

  always_comb begin
    target   = {item_q.sample, 8'd0};
    step     = prod_q[49:16];
    m95      = (((rd_data_q ^ pre95_q) & mask_q) == '0) && ((rd_data_q & bit_q) == '0);
    m99      = (((rd_data_q ^ pre99_q) & mask_q) == '0) && ((rd_data_q & bit_q) == '0);
    c95_n    = cnt95_q + CW'(m95);
    c99_n    = cnt99_q + CW'(m99);
    q95_p    = x95_q * RECIP;
    q99_p    = x99_q * RECIP;
    mem_we   = (state_q == S_WRITE) && item_q.nonzero;
    mem_re   = (state_q == S_SCAN) && iss_q;
    out_load = (state_q == S_DONE) && (!out_vld_q || !out_stall_i);
    pop_o    = (state_q == S_IDLE) && item_valid_i;
    state_d  = state_q;
    case (state_q)
      S_IDLE:  if (item_valid_i) state_d = S_WRITE;
      S_WRITE: state_d = S_MUL;
      S_MUL:   state_d = S_ADD;
      S_ADD:   state_d = (fill_q == '0) ? S_DONE : S_SCAN;
      S_SCAN:  if (rd_vld_q && rd_last_q && bit_q[0]) state_d = S_DONE;
      S_DONE:  if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Window memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[slot_q] <= SW'(item_q.sample);
    end
    if (mem_re) begin
      rd_data_q <= mem[rd_addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      slot_q    <= '0;
      fill_q    <= '0;
      avg_q     <= '0;
      iss_q     <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      rd_addr_q <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= mem_re;
      if (mem_re) begin
        rd_last_q <= (CW'(rd_addr_q) == fill_q - CW'(1));
        if (CW'(rd_addr_q) == fill_q - CW'(1)) begin
          iss_q <= 1'b0;
        end else begin
          rd_addr_q <= rd_addr_q + AW'(1);
        end
      end
      if (mem_we) begin
        slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + AW'(1);
        if (fill_q < DEPTH_C) fill_q <= fill_q + CW'(1);
      end
      if (state_q == S_ADD) begin
        avg_q     <= avg_zero_q ? target : AVG_W'($signed({2'b00, avg_q}) + step);
        iss_q     <= (fill_q != '0);
        rd_addr_q <= '0;
      end
      if (state_q == S_SCAN && rd_vld_q && rd_last_q && !bit_q[0]) begin
        iss_q     <= 1'b1;
        rd_addr_q <= '0;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (pop_o) item_q <= item_i;
    if (state_q == S_WRITE) begin
      avg_zero_q <= (avg_q == '0);
      diff_q     <= $signed({1'b0, target}) - $signed({1'b0, avg_q});
    end
    if (state_q == S_MUL) begin
      prod_q <= diff_q * $signed({1'b0, cfg_i.alpha});
      x95_q  <= XW'(fill_q) * XW'(95) + XW'(99);
      x99_q  <= XW'(fill_q) * XW'(99) + XW'(99);
    end
    if (state_q == S_ADD) begin
      r95_q   <= CW'(q95_p >> 32) - CW'(1);
      r99_q   <= CW'(q99_p >> 32) - CW'(1);
      pre95_q <= '0;
      pre99_q <= '0;
      mask_q  <= '0;
      bit_q   <= {1'b1, {(SW-1){1'b0}}};
      cnt95_q <= '0;
      cnt99_q <= '0;
      max_q   <= '0;
      hitch_q <= '0;
      first_q <= 1'b1;
    end
    if (state_q == S_SCAN && rd_vld_q) begin
      cnt95_q <= c95_n;
      cnt99_q <= c99_n;
      if (first_q) begin
        if (rd_data_q > max_q) max_q <= rd_data_q;
        if (32'(rd_data_q) > 32'(cfg_i.threshold)) hitch_q <= hitch_q + CW'(1);
      end
      if (rd_last_q) begin
        // Settle one bit of each ranked value: stay in the lower half or step past it.
        if (r95_q >= c95_n) begin
          pre95_q <= pre95_q | bit_q;
          r95_q   <= r95_q - c95_n;
        end
        if (r99_q >= c99_n) begin
          pre99_q <= pre99_q | bit_q;
          r99_q   <= r99_q - c99_n;
        end
        cnt95_q <= '0;
        cnt99_q <= '0;
        first_q <= 1'b0;
        mask_q  <= mask_q | bit_q;
        bit_q   <= bit_q >> 1;
      end
    end
    if (out_load) begin
      current_frame_us_o  <= item_q.sample;
      smoothed_frame_q8_o <= avg_q;
      p95_frame_us_o      <= FRAME_W'(pre95_q);
      p99_frame_us_o      <= FRAME_W'(pre99_q);
      max_frame_us_o      <= FRAME_W'(max_q);
      hitch_total_o       <= OCNT_W'(hitch_q);
      window_fill_o       <= OCNT_W'(fill_q);
    end
  end

  assign out_valid_o = out_vld_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DEPTH_C) else $error("fill level above window depth");
  a_read_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_re |-> (CW'(rd_addr_q) < fill_q)) else $error("read beyond filled window");
  a_bit_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> $onehot(bit_q)) else $error("scan bit select not onehot");
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == S_WRITE)) else $error("pop did not start an item");

endmodule

// ----- hdl/sliding_window_frame_percentiles.sv -----
// The engine handles one word at a time and takes the next only after its result word
//   is loaded; the radix selection makes one pass over the window memory read port
//   per sample bit, both percentiles sharing each pass, and is skipped when the window is empty.
// A two-word queue lets the input side run ahead of the engine.
// Reset (rst_ni, async, active low) restores register defaults, empties the window
//   and zeroes the average; the window memory itself is not cleared.
module sliding_window_frame_percentiles import swfp_pkg::*; #(
  parameter int WINDOW_DEPTH = 240,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // input words
  input  logic               in_valid_i,
  input  logic [FRAME_W-1:0] frame_time_us_i,
  output logic               in_stall_o,
  // result words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [FRAME_W-1:0] current_frame_us_o,
  output logic [AVG_W-1:0]   smoothed_frame_q8_o,
  output logic [FRAME_W-1:0] p95_frame_us_o,
  output logic [FRAME_W-1:0] p99_frame_us_o,
  output logic [FRAME_W-1:0] max_frame_us_o,
  output logic [OCNT_W-1:0]  hitch_total_o,
  output logic [OCNT_W-1:0]  window_fill_o
);

  cfg_t  cfg_q;
  item_t item;
  logic  item_valid, pop, wr_en;

  // Registers sit at byte addresses 0 and 4; address bit 2 picks the register.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_HITCH: prdata = 32'(cfg_q.threshold);
      REG_ALPHA: prdata = 32'(cfg_q.alpha);
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESH_RST;
      cfg_q.alpha     <= ALPHA_RST;
    end else if (wr_en) begin
      case (paddr[2])
        REG_HITCH: cfg_q.threshold <= pwdata[FRAME_W-1:0];
        REG_ALPHA: cfg_q.alpha     <= pwdata[ALPHA_W-1:0];
        default:   cfg_q.alpha     <= cfg_q.alpha;
      endcase
    end
  end

  // Accept and classify each word, hold it until the engine is free.
  swfp_front #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .frame_time_us_i(frame_time_us_i),
    .in_stall_o     (in_stall_o),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .pop_i          (pop)
  );

  // Update window and average, then rank-select and register the result word.
  swfp_back #(
    .WINDOW_DEPTH(WINDOW_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .item_valid_i       (item_valid),
    .item_i             (item),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .current_frame_us_o (current_frame_us_o),
    .smoothed_frame_q8_o(smoothed_frame_q8_o),
    .p95_frame_us_o     (p95_frame_us_o),
    .p99_frame_us_o     (p99_frame_us_o),
    .max_frame_us_o     (max_frame_us_o),
    .hitch_total_o      (hitch_total_o),
    .window_fill_o      (window_fill_o)
  );

endmodule
